>>> rtl/core/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] value;
		logic signed [31:0] priority_req;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic signed [31:0] out_priority;
		logic [OCC_W-1:0]   occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

endpackage

>>> rtl/core/spq_ctrl.sv
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output spq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	assign busy     = (state_q == S_EXEC);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.exec = (state_q == S_EXEC);
	assign done     = done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> cmd.exec)
		else $error("accepted beat did not reach execute");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (done && !busy))
		else $error("execute not followed by result strobe");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

>>> rtl/core/spq_dpath.sv
module spq_dpath import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  spq_cmd_t cmd,
	input  spq_req_t req,
	output spq_rsp_t rsp
);

	logic signed [31:0] val_q [CAPACITY];
	logic signed [31:0] pri_q [CAPACITY];
	logic signed [31:0] val_d [CAPACITY];
	logic signed [31:0] pri_d [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [CAPACITY-1:0] keep;
	spq_req_t           req_q;
	spq_rsp_t           rsp_q;
	spq_rsp_t           rsp_d;
	logic               full;
	logic               empty;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// keep marks held entries that stay ahead of the new one (a prefix, list is sorted)
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			keep[i] = (CNT_W'(i) < count_q) && !(pri_q[i] > req_q.priority_req);
		end
	end

	always_comb begin
		count_d = count_q;
		rsp_d   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			val_d[i] = val_q[i];
			pri_d[i] = pri_q[i];
		end
		if (req_q.opcode == OP_ENQ) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.status = ST_OK;
				count_d      = count_q + CNT_W'(1);
				for (int i = 0; i < CAPACITY; i++) begin
					if (!keep[i]) begin
						if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
							val_d[i] = req_q.value;
							pri_d[i] = req_q.priority_req;
						end else begin
							val_d[i] = val_q[(i == 0) ? 0 : i - 1];
							pri_d[i] = pri_q[(i == 0) ? 0 : i - 1];
						end
					end
				end
			end
		end else begin
			if (empty) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.status       = ST_OK;
				rsp_d.out_value    = val_q[0];
				rsp_d.out_priority = pri_q[0];
				count_d            = count_q - CNT_W'(1);
				// advance every entry one place toward the head
				for (int i = 0; i < CAPACITY - 1; i++) begin
					val_d[i] = val_q[i + 1];
					pri_d[i] = pri_q[i + 1];
				end
			end
		end
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
			for (int i = 0; i < CAPACITY; i++) begin
				val_q[i] <= val_d[i];
				pri_q[i] <= pri_d[i];
			end
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q.opcode == OP_DEQ && !empty) |=>
		(count_q == $past(count_q) - CNT_W'(1)))
		else $error("dequeue did not drop one entry");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && req_q.opcode == OP_ENQ && full) |=>
		($stable(count_q) && rsp_q.status == ST_FULL))
		else $error("enqueue on full queue changed state");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count moved outside execute");

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Channel  | Ports                      | Handshake
// ---------+----------------------------+----------------------------------
// request  | start, busy, req           | beat taken when start && !busy
// result   | done, rsp                  | one-cycle strobe, cannot be held off
//
// Each request is captured, then executed: on an enqueue all held entries
// compare with the new priority at once; those ranked behind it shift in parallel.
// The result strobes in the cycle after execute; a new start is taken then.
// Reset clears the entry count and controller; entry storage is not cleared.
// The receiver cannot stall, so results are never held back.
module sorted_priority_queue import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t req,
	output logic     done,
	output spq_rsp_t rsp
);

	spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	spq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
